// File: hdl/clcd_pkg.sv
package clcd_pkg;

  typedef enum logic [1:0] {
    KindTick       = 2'd0,
    KindSetVoltage = 2'd1,
    KindSetCurrent = 2'd2,
    KindSetTarget  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CfgPowerOnWait = 2'd0,
    CfgClearWait   = 2'd1,
    CfgRefreshWait = 2'd2,
    CfgUnused      = 2'd3
  } cfg_index_e;

  typedef struct packed {
    kind_e       kind;
    logic        busy_req;
    logic [15:0] value;
  } in_beat_t;

  typedef struct packed {
    logic       register_select;
    logic [7:0] bus_byte;
    logic       last_of_run;
  } out_beat_t;

  localparam int unsigned CfgWidth = 8;

  localparam logic [7:0] CmdFuncSet   = 8'h33;
  localparam logic [7:0] CmdDispOn    = 8'h0F;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdEntryMode = 8'h06;
  localparam logic [7:0] CmdHome      = 8'h02;

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharIcon  = 8'h11;
  localparam logic [7:0] CharVolt  = 8'h56;
  localparam logic [7:0] CharAmp   = 8'h41;
  localparam logic [7:0] CharPoint = 8'h2E;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;

  // Only the first sixteen slots are ever written; the rest of the line stays blank.
  localparam int unsigned BufSlots  = 16;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned CurrSlot  = 5;
  localparam int unsigned TargSlot  = 12;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = 2;
  localparam int unsigned CntW      = 3;

  // Exact quotient by ten for any 8-bit value.
  function automatic logic [4:0] div10(input logic [7:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd205;
    return p[15:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [7:0] x);
    logic [7:0] q10;
    q10 = 8'(div10(x)) * 8'd10;
    return 4'(x - q10);
  endfunction

  function automatic out_beat_t cmd_beat(input logic [7:0] b);
    out_beat_t r;
    r.register_select = 1'b0;
    r.bus_byte        = b;
    r.last_of_run     = 1'b0;
    return r;
  endfunction

endpackage

// File: hdl/char_lcd_init_refresh_controller_unit.sv
// Character LCD controller for an 8-bit HD44780-style bus.
// Input channel (in_valid_i/in_ready_o, in_beat_i): one beat is either a tick,
// carrying the sampled busy flag, or a set beat that formats a voltage or a
// current reading into the character buffer. Ticks step the start-up sequence
// and the periodic refresh, and each tick produces zero, one or two bus writes.
// Output channel (out_valid_o/out_ready_i, out_beat_o): one beat per bus write,
// with last_of_run marking the final write caused by a tick.
// A beat is processed in the cycle it is accepted, and its writes are registered
// into the output queue. One input beat is accepted per cycle as long as the
// four-entry output queue has room for two writes, so the rate is one beat per
// cycle, limited only by how fast the receiver drains writes. When the receiver
// stalls, the queue fills and in_ready_o drops; nothing is lost. The user must write
// the three wait registers through the configuration port when the block is idle;
// the block itself does not enforce this. Reset puts the sequencer in the power-on
// wait, restores the default waits, fills the buffer with spaces and the icon
// character in slot zero, and empties the queue.
module char_lcd_init_refresh_controller_unit #(
  parameter int unsigned DISPLAY_CHARS  = 16,
  parameter int unsigned VOLT_FRAC_BITS = 11,
  parameter int unsigned CURR_FRAC_BITS = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  clcd_pkg::in_beat_t         in_beat_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output clcd_pkg::out_beat_t        out_beat_o,
  input  logic                       cfg_we_i,
  input  clcd_pkg::cfg_index_e       cfg_index_i,
  input  logic [clcd_pkg::CfgWidth-1:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(DISPLAY_CHARS + 1);
  localparam logic [15:0] VoltMask = 16'((32'd1 << VOLT_FRAC_BITS) - 32'd1);
  localparam logic [15:0] CurrMask = 16'((32'd1 << CURR_FRAC_BITS) - 32'd1);

  typedef enum logic [8:0] {
    PhPowerWait = 9'b000000001,
    PhFuncSet2  = 9'b000000010,
    PhDispOn    = 9'b000000100,
    PhClear     = 9'b000001000,
    PhEntry     = 9'b000010000,
    PhSettle    = 9'b000100000,
    PhIdle      = 9'b001000000,
    PhHome      = 9'b010000000,
    PhWrite     = 9'b100000000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [7:0]          tick_q, tick_d;
  logic [IdxW-1:0]     widx_q, widx_d;
  logic [IdxW-1:0]     widx_inc;
  logic [7:0]          power_wait_q, clear_wait_q, refresh_wait_q;
  logic [7:0]          chars_q [clcd_pkg::BufSlots];
  logic [7:0]          rd_char;

  clcd_pkg::out_beat_t fifo_q [clcd_pkg::FifoDepth];
  logic [clcd_pkg::PtrW-1:0] wr_q, rd_q;
  logic [clcd_pkg::CntW-1:0] count_q;

  logic                in_acc, is_tick, busy, pop;
  logic [1:0]          n_push;
  clcd_pkg::out_beat_t b0, b1;

  logic [7:0]          v_ip, c_ip;
  logic [19:0]         v_frac10, c_frac10;
  logic [7:0]          v_tens, v_units, v_tenths, c_int, c_tenths;

  assign in_ready_o = (count_q <= clcd_pkg::CntW'(clcd_pkg::FifoDepth - 2));
  assign in_acc     = in_valid_i && in_ready_o;
  assign is_tick    = (in_beat_i.kind == clcd_pkg::KindTick);
  assign busy       = in_beat_i.busy_req;
  assign out_valid_o = (count_q != '0);
  assign out_beat_o  = fifo_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;

  // Number formatting for set beats.
  assign v_ip     = 8'(in_beat_i.value >> VOLT_FRAC_BITS);
  assign v_frac10 = (20'(in_beat_i.value & VoltMask) * 20'd10) >> VOLT_FRAC_BITS;
  assign v_tens   = clcd_pkg::CharZero + 8'(clcd_pkg::mod10(8'(clcd_pkg::div10(v_ip))));
  assign v_units  = clcd_pkg::CharZero + 8'(clcd_pkg::mod10(v_ip));
  assign v_tenths = clcd_pkg::CharZero + v_frac10[7:0];
  assign c_ip     = 8'(in_beat_i.value >> CURR_FRAC_BITS);
  assign c_frac10 = (20'(in_beat_i.value & CurrMask) * 20'd10) >> CURR_FRAC_BITS;
  assign c_int    = clcd_pkg::CharZero + c_ip;
  assign c_tenths = clcd_pkg::CharZero + c_frac10[7:0];

  assign rd_char  = (widx_q < IdxW'(clcd_pkg::BufSlots)) ?
                    chars_q[widx_q[clcd_pkg::SlotW-1:0]] : clcd_pkg::CharSpace;
  assign widx_inc = widx_q + IdxW'(1);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    widx_d  = widx_q;
    n_push  = 2'd0;
    b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdFuncSet);
    b1      = clcd_pkg::cmd_beat(clcd_pkg::CmdDispOn);
    if (in_acc && is_tick) begin
      unique case (phase_q)
        PhPowerWait: begin
          if (tick_q > power_wait_q) begin
            b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdFuncSet);
            n_push  = 2'd1;
            phase_d = PhFuncSet2;
            tick_d  = '0;
          end else begin
            tick_d = tick_q + 8'd1;
          end
        end
        PhFuncSet2: begin
          b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdFuncSet);
          n_push  = 2'd1;
          phase_d = PhDispOn;
          if (!busy) begin
            b1      = clcd_pkg::cmd_beat(clcd_pkg::CmdDispOn);
            n_push  = 2'd2;
            phase_d = PhClear;
          end
        end
        PhDispOn: begin
          if (!busy) begin
            b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdDispOn);
            n_push  = 2'd1;
            phase_d = PhClear;
          end
        end
        PhClear: begin
          if (!busy) begin
            b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdClear);
            n_push  = 2'd1;
            phase_d = PhEntry;
            tick_d  = '0;
          end
        end
        PhEntry: begin
          if (tick_q > clear_wait_q) begin
            if (!busy) begin
              b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdEntryMode);
              n_push  = 2'd1;
              phase_d = PhSettle;
              tick_d  = '0;
            end
          end else begin
            tick_d = tick_q + 8'd1;
          end
        end
        PhSettle: begin
          if (!busy) begin
            phase_d = PhIdle;
          end
        end
        PhIdle: begin
          if (!busy) begin
            if (tick_q > refresh_wait_q) begin
              phase_d = PhHome;
              widx_d  = '0;
              tick_d  = '0;
            end else begin
              tick_d = tick_q + 8'd1;
            end
          end
        end
        PhHome: begin
          if (!busy) begin
            b0      = clcd_pkg::cmd_beat(clcd_pkg::CmdHome);
            n_push  = 2'd1;
            phase_d = PhWrite;
          end
        end
        PhWrite: begin
          if (!busy) begin
            b0.register_select = 1'b1;
            b0.bus_byte        = rd_char;
            n_push             = 2'd1;
            if (widx_inc >= IdxW'(DISPLAY_CHARS)) begin
              phase_d = PhIdle;
              widx_d  = '0;
            end else begin
              widx_d = widx_inc;
            end
          end
        end
        default: begin
          phase_d = PhPowerWait;
        end
      endcase
    end
    b0.last_of_run = (n_push == 2'd1);
    b1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PhPowerWait;
      tick_q         <= '0;
      widx_q         <= '0;
      power_wait_q   <= 8'd20;
      clear_wait_q   <= 8'd1;
      refresh_wait_q <= 8'd100;
      wr_q           <= '0;
      rd_q           <= '0;
      count_q        <= '0;
      for (int i = 0; i < int'(clcd_pkg::BufSlots); i++) begin
        chars_q[i] <= (i == 0) ? clcd_pkg::CharIcon : clcd_pkg::CharSpace;
      end
    end else begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      widx_q  <= widx_d;
      wr_q    <= wr_q + clcd_pkg::PtrW'(n_push);
      rd_q    <= rd_q + clcd_pkg::PtrW'(pop);
      count_q <= count_q + clcd_pkg::CntW'(n_push) - clcd_pkg::CntW'(pop);
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          clcd_pkg::CfgPowerOnWait: power_wait_q   <= cfg_wdata_i;
          clcd_pkg::CfgClearWait:   clear_wait_q   <= cfg_wdata_i;
          clcd_pkg::CfgRefreshWait: refresh_wait_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        case (in_beat_i.kind)
          clcd_pkg::KindSetVoltage: begin
            chars_q[0] <= v_tens;
            chars_q[1] <= v_units;
            chars_q[2] <= clcd_pkg::CharVolt;
            chars_q[3] <= v_tenths;
          end
          clcd_pkg::KindSetCurrent: begin
            chars_q[clcd_pkg::CurrSlot - 1] <= clcd_pkg::CharSlash;
            chars_q[clcd_pkg::CurrSlot]     <= c_int;
            chars_q[clcd_pkg::CurrSlot + 1] <= clcd_pkg::CharPoint;
            chars_q[clcd_pkg::CurrSlot + 2] <= c_tenths;
            chars_q[clcd_pkg::CurrSlot + 3] <= clcd_pkg::CharAmp;
          end
          clcd_pkg::KindSetTarget: begin
            chars_q[clcd_pkg::TargSlot]     <= c_int;
            chars_q[clcd_pkg::TargSlot + 1] <= clcd_pkg::CharPoint;
            chars_q[clcd_pkg::TargSlot + 2] <= c_tenths;
            chars_q[clcd_pkg::TargSlot + 3] <= clcd_pkg::CharAmp;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_q] <= b0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_q + clcd_pkg::PtrW'(1)] <= b1;
    end
  end

`ifndef SYNTHESIS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= clcd_pkg::CntW'(clcd_pkg::FifoDepth))
    else $error("Output queue holds more beats than it has entries.");

  a_set_no_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !is_tick) |=> (count_q <= $past(count_q)))
    else $error("A set beat added writes to the output queue.");

  a_tick_keeps_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_tick) |=> $stable(chars_q[0]))
    else $error("A tick beat changed the character buffer.");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int DispChars   = 16;
  localparam int VoltFrac    = 11;
  localparam int CurrFrac    = 12;
  localparam int SettleCycles = 6;
  localparam int HoldCycles  = 80;
  localparam int CycleLimit  = 200000;

  typedef enum logic [3:0] {
    SeqPowerWait = 4'd0,
    SeqFuncSet2  = 4'd1,
    SeqDispOn    = 4'd2,
    SeqClear     = 4'd3,
    SeqEntry     = 4'd4,
    SeqSettle    = 4'd5,
    SeqIdle      = 4'd6,
    SeqHome      = 4'd7,
    SeqWrite     = 4'd8
  } seq_e;

  class bus_write_tracker;
    logic [7:0] power_wait;
    logic [7:0] clear_wait;
    logic [7:0] refresh_wait;
    seq_e       seq;
    logic [7:0] tick_cnt;
    logic [6:0] slot_idx;
    logic [7:0] screen [DispChars];
    clcd_pkg::out_beat_t writes_due [$];
    int         errors;
    int         beats_taken;
    int         writes_checked;

    function new();
      power_wait   = 8'd20;
      clear_wait   = 8'd1;
      refresh_wait = 8'd100;
      seq          = SeqPowerWait;
      tick_cnt     = '0;
      slot_idx     = '0;
      foreach (screen[i]) screen[i] = clcd_pkg::CharSpace;
      screen[0]      = clcd_pkg::CharIcon;
      errors         = 0;
      beats_taken    = 0;
      writes_checked = 0;
    endfunction

    function void set_reg(clcd_pkg::cfg_index_e idx, logic [7:0] v);
      case (idx)
        clcd_pkg::CfgPowerOnWait: power_wait = v;
        clcd_pkg::CfgClearWait:   clear_wait = v;
        clcd_pkg::CfgRefreshWait: refresh_wait = v;
        default: ;
      endcase
    endfunction

    function void push_write(logic rs, logic [7:0] b);
      clcd_pkg::out_beat_t w;
      w.register_select = rs;
      w.bus_byte        = b;
      w.last_of_run     = 1'b0;
      writes_due.push_back(w);
    endfunction

    function void put_reading(logic [15:0] v, int at, bit slash);
      int vi;
      int ip;
      int fr;
      vi = int'(v);
      ip = (vi >> CurrFrac) & 'hFF;
      fr = ((vi & ((1 << CurrFrac) - 1)) * 10) >> CurrFrac;
      if (slash) screen[at - 1] = clcd_pkg::CharSlash;
      screen[at]     = 8'(ip + int'(clcd_pkg::CharZero));
      screen[at + 1] = clcd_pkg::CharPoint;
      screen[at + 2] = 8'(fr + int'(clcd_pkg::CharZero));
      screen[at + 3] = clcd_pkg::CharAmp;
    endfunction

    function void take_beat(clcd_pkg::in_beat_t b);
      int vi;
      int ip;
      int fr;
      int n0;
      beats_taken++;
      vi = int'(b.value);
      case (b.kind)
        clcd_pkg::KindSetVoltage: begin
          ip = (vi >> VoltFrac) & 'hFF;
          fr = ((vi & ((1 << VoltFrac) - 1)) * 10) >> VoltFrac;
          screen[0] = 8'(((ip / 10) % 10) + int'(clcd_pkg::CharZero));
          screen[1] = 8'((ip % 10) + int'(clcd_pkg::CharZero));
          screen[2] = clcd_pkg::CharVolt;
          screen[3] = 8'(fr + int'(clcd_pkg::CharZero));
          return;
        end
        clcd_pkg::KindSetCurrent: begin
          put_reading(b.value, clcd_pkg::CurrSlot, 1'b1);
          return;
        end
        clcd_pkg::KindSetTarget: begin
          put_reading(b.value, clcd_pkg::TargSlot, 1'b0);
          return;
        end
        default: ;
      endcase
      n0 = writes_due.size();
      case (seq)
        SeqPowerWait: begin
          if (tick_cnt > power_wait) begin
            push_write(1'b0, clcd_pkg::CmdFuncSet);
            seq      = SeqFuncSet2;
            tick_cnt = '0;
          end else begin
            tick_cnt = tick_cnt + 8'd1;
          end
        end
        SeqFuncSet2: begin
          push_write(1'b0, clcd_pkg::CmdFuncSet);
          seq = SeqDispOn;
          if (!b.busy_req) begin
            push_write(1'b0, clcd_pkg::CmdDispOn);
            seq = SeqClear;
          end
        end
        SeqDispOn: begin
          if (!b.busy_req) begin
            push_write(1'b0, clcd_pkg::CmdDispOn);
            seq = SeqClear;
          end
        end
        SeqClear: begin
          if (!b.busy_req) begin
            push_write(1'b0, clcd_pkg::CmdClear);
            seq      = SeqEntry;
            tick_cnt = '0;
          end
        end
        SeqEntry: begin
          if (tick_cnt > clear_wait) begin
            if (!b.busy_req) begin
              push_write(1'b0, clcd_pkg::CmdEntryMode);
              seq      = SeqSettle;
              tick_cnt = '0;
            end
          end else begin
            tick_cnt = tick_cnt + 8'd1;
          end
        end
        SeqSettle: begin
          if (!b.busy_req) seq = SeqIdle;
        end
        SeqIdle: begin
          if (!b.busy_req) begin
            if (tick_cnt > refresh_wait) begin
              seq      = SeqHome;
              slot_idx = '0;
              tick_cnt = '0;
            end else begin
              tick_cnt = tick_cnt + 8'd1;
            end
          end
        end
        SeqHome: begin
          if (!b.busy_req) begin
            push_write(1'b0, clcd_pkg::CmdHome);
            seq = SeqWrite;
          end
        end
        SeqWrite: begin
          if (!b.busy_req) begin
            if (slot_idx < DispChars) begin
              push_write(1'b1, screen[slot_idx]);
              slot_idx = slot_idx + 7'd1;
            end
            if (slot_idx >= DispChars) begin
              seq      = SeqIdle;
              slot_idx = '0;
            end
          end
        end
        default: seq = SeqPowerWait;
      endcase
      if (writes_due.size() > n0) writes_due[writes_due.size() - 1].last_of_run = 1'b1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_write(clcd_pkg::out_beat_t got);
      clcd_pkg::out_beat_t want;
      writes_checked++;
      if (writes_due.size() == 0) begin
        report($sformatf("bus write rs=%0b byte=%02h last=%0b with none due",
                         got.register_select, got.bus_byte, got.last_of_run));
        return;
      end
      want = writes_due.pop_front();
      if (got.register_select !== want.register_select)
        report($sformatf("write %0d: register_select %0b, want %0b",
                         writes_checked, got.register_select, want.register_select));
      if (got.bus_byte !== want.bus_byte)
        report($sformatf("write %0d: bus_byte %02h, want %02h",
                         writes_checked, got.bus_byte, want.bus_byte));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("write %0d: last_of_run %0b, want %0b",
                         writes_checked, got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic       clk_i;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  clcd_pkg::in_beat_t   in_beat;
  logic       out_valid;
  logic       out_ready;
  clcd_pkg::out_beat_t  out_beat;
  logic       cfg_we;
  clcd_pkg::cfg_index_e cfg_index;
  logic [7:0] cfg_wdata;

  bus_write_tracker board = new();
  bit quiet;
  bit hold_req;
  int cycles;

  char_lcd_init_refresh_controller_unit #(
    .DISPLAY_CHARS (DispChars),
    .VOLT_FRAC_BITS(VoltFrac),
    .CURR_FRAC_BITS(CurrFrac)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_beat_o (out_beat),
    .cfg_we_i   (cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Run stopped at the cycle limit with %0d bus writes still due.",
             board.writes_due.size());
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) board.check_write(out_beat);
  end

  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      if (!quiet && stall_left == 0 && $urandom_range(0, 11) == 0)
        stall_left = $urandom_range(1, 19);
      if (stall_left > 0 && !quiet) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = 0;
        out_ready <= 1'b1;
      end
    end
  end

  function automatic clcd_pkg::in_beat_t mk_beat(clcd_pkg::kind_e k, logic busy,
                                                 logic [15:0] v);
    clcd_pkg::in_beat_t b;
    b.kind     = k;
    b.busy_req = busy;
    b.value    = v;
    return b;
  endfunction

  function automatic clcd_pkg::in_beat_t rand_beat();
    clcd_pkg::in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 76) b.kind = clcd_pkg::KindTick;
    else b.kind = clcd_pkg::kind_e'($urandom_range(1, 3));
    b.busy_req = ($urandom_range(0, 3) == 0);
    b.value    = 16'($urandom);
    if ($urandom_range(0, 15) == 0) b.value = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    return b;
  endfunction

  task automatic send_beat(input clcd_pkg::in_beat_t b);
    in_valid <= 1'b1;
    in_beat  <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    board.take_beat(b);
  endtask

  task automatic run_random(input int n, input bit gaps);
    for (int k = 0; k < n; k++) begin
      send_beat(rand_beat());
      if (gaps && !quiet && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (board.writes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input clcd_pkg::cfg_index_e idx, input logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    board.set_reg(idx, v);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    bit dir_busy [19];
    dir_busy = '{1, 0, 1, 1, 0, 1, 0, 1, 1, 1, 1, 0, 1, 0, 1, 0, 0, 0, 0};
    quiet     = 1'b0;
    hold_req  = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_beat   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= clcd_pkg::CfgPowerOnWait;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_reg(clcd_pkg::CfgPowerOnWait, 8'd2);
    write_reg(clcd_pkg::CfgClearWait, 8'd2);
    write_reg(clcd_pkg::CfgRefreshWait, 8'd0);
    write_reg(clcd_pkg::CfgUnused, 8'h5A);

    // Formatting extremes, then the start-up sequence up to the start of the first refresh.
    send_beat(mk_beat(clcd_pkg::KindSetVoltage, 1'b0, 16'h0000));
    send_beat(mk_beat(clcd_pkg::KindSetVoltage, 1'b1, 16'hFFFF));
    send_beat(mk_beat(clcd_pkg::KindSetCurrent, 1'b0, 16'hFFFF));
    send_beat(mk_beat(clcd_pkg::KindSetTarget, 1'b1, 16'h0000));
    send_beat(mk_beat(clcd_pkg::KindSetTarget, 1'b0, 16'hFFFF));
    foreach (dir_busy[i])
      send_beat(mk_beat(clcd_pkg::KindTick, dir_busy[i], 16'(i * 16'h0F0F)));
    settle_block();

    run_random(40, 1'b1);
    hold_req = 1'b1;
    run_random(30, 1'b0);
    run_random(50, 1'b1);
    settle_block();

    write_reg(clcd_pkg::CfgRefreshWait, 8'($urandom_range(1, 12)));
    write_reg(clcd_pkg::CfgClearWait, 8'd0);
    write_reg(clcd_pkg::CfgPowerOnWait, 8'd254);
    run_random(120, 1'b1);
    settle_block();

    write_reg(clcd_pkg::CfgRefreshWait, 8'd254);
    run_random(30, 1'b1);
    settle_block();

    write_reg(clcd_pkg::CfgRefreshWait, 8'd255);
    run_random(40, 1'b1);
    settle_block();

    write_reg(clcd_pkg::CfgUnused, 8'hA5);
    write_reg(clcd_pkg::CfgRefreshWait, 8'd0);
    write_reg(clcd_pkg::CfgPowerOnWait, 8'd0);
    write_reg(clcd_pkg::CfgClearWait, 8'd254);
    quiet = 1'b1;
    run_random(120, 1'b1);
    settle_block();

    if (board.writes_due.size() != 0)
      board.report($sformatf("%0d bus writes never arrived", board.writes_due.size()));
    $display("Covered %0d input beats and %0d bus writes: start-up, refreshes, all set kinds.",
             board.beats_taken, board.writes_checked);
    $display("Refresh waits ran from 0 to 255, with a long receiver stall filling the queue.");
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
